// File: hdl/bf_pkg.sv
// Shared types, codes and constants for the salted Bloom filter.
// Holds the beat structs, the control state enum and the salt generator.
// No dependencies.
package bf_pkg;

  localparam int MODE_W     = 2;
  localparam int BYTE_W     = 8;
  localparam int FBITS_W    = 17;
  localparam int HCOUNT_W   = 5;
  localparam int COUNT_W    = 17;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 17;
  localparam int HASH_W     = 64;
  localparam int SALT_W     = 32;
  // remainder bits retired per cycle by the modulo unit
  localparam int DIV_STEPS  = 2;
  // filter cells packed per memory row
  localparam int ROW_BITS   = 8;

  localparam logic [HASH_W-1:0]   HASH_SEED         = 64'd5381;
  localparam logic [FBITS_W-1:0]  FILTER_BITS_RESET = 17'd1000;
  localparam logic [HCOUNT_W-1:0] HASH_COUNT_RESET  = 5'd4;

  // operation codes
  localparam logic [MODE_W-1:0] MODE_ADD   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_QUERY = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;
  localparam logic [MODE_W-1:0] MODE_NONE  = 2'd3;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FILTER_BITS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HASH_COUNT  = 2'd1;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [BYTE_W-1:0] key_byte;
    logic              has_byte;
    logic              last_byte;
  } req_t;

  typedef struct packed {
    logic [MODE_W-1:0]  done_mode;
    logic               found;
    logic [COUNT_W-1:0] set_bit_count;
  } rsp_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIV_HI,
    ST_DIV_LO,
    ST_READ,
    ST_CHECK,
    ST_FINISH
  } state_t;

  // reflected CRC-32 table entry for one byte (poly 0xEDB88320)
  function automatic logic [SALT_W-1:0] crc_entry(input logic [7:0] b);
    logic [SALT_W-1:0] c;
    c = {24'b0, b};
    for (int n = 0; n < 8; n++) begin
      c = c[0] ? (32'hEDB88320 ^ (c >> 1)) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// File: hdl/bf_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module bf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8192
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// File: hdl/bloom_filter_djb2_salted.sv
// Salted Bloom filter, djb2 key hash. A key beat that is not final is folded into the hash while idle.
// A final add or query beat is worked through states: the modulo unit retires 2 remainder bits a
// cycle, reducing the upper hash half once and the lower half once per probe; each probe then takes
// a read and a read-modify-write step, and the output register is loaded last, once a waiting
// response has been taken; the next beat is taken after that. One item is worked at a time.
// A clear beat, reset, and a write to either register sweep the store one 8-cell row a cycle,
// over all ceil(MAX_BITS/8) rows (8192 by default), with req_ready low; clear then returns its beat.
module bloom_filter_djb2_salted #(
  parameter int MAX_BITS   = 65536,
  parameter int MAX_HASHES = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             req_valid,
  output logic                             req_ready,
  input  bf_pkg::req_t                     req,
  output logic                             rsp_valid,
  input  logic                             rsp_ready,
  output bf_pkg::rsp_t                     rsp,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [bf_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [bf_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import bf_pkg::*;

  localparam int IW      = $clog2(MAX_BITS + 1);
  localparam int ROWS    = (MAX_BITS + ROW_BITS - 1) / ROW_BITS;
  localparam int RAW     = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int BSW     = $clog2(ROW_BITS);
  localparam int KW      = $clog2(MAX_HASHES + 1);
  localparam int HALF_W  = HASH_W / 2;
  localparam int DIV_CYC = HALF_W / DIV_STEPS;
  localparam int DCW     = $clog2(DIV_CYC);

  // clamp filter_bits into 1..MAX_BITS
  function automatic logic [IW-1:0] eff_bits(input logic [FBITS_W-1:0] v);
    logic [31:0] w;
    w = 32'(v);
    if (v == '0) return IW'(1);
    if (w > 32'(MAX_BITS)) return IW'(MAX_BITS);
    return IW'(v);
  endfunction

  // clamp hash_count into 1..MAX_HASHES
  function automatic logic [KW-1:0] eff_hashes(input logic [HCOUNT_W-1:0] v);
    logic [31:0] w;
    w = 32'(v);
    if (v == '0) return KW'(1);
    if (w > 32'(MAX_HASHES)) return KW'(MAX_HASHES);
    return KW'(v);
  endfunction

  // restoring remainder step, DIV_STEPS dividend bits MSB first; needs r < m
  function automatic logic [IW-1:0] div_step(input logic [IW-1:0] r,
                                             input logic [DIV_STEPS-1:0] bits,
                                             input logic [IW-1:0] m);
    logic [IW:0]   t;
    logic [IW-1:0] acc;
    acc = r;
    for (int s = DIV_STEPS - 1; s >= 0; s--) begin
      t = {acc, bits[s]};
      if (t >= {1'b0, m}) t = t - {1'b0, m};
      acc = t[IW-1:0];
    end
    return acc;
  endfunction

  state_t state, state_next;

  logic [HASH_W-1:0]   hash_acc;
  logic [HALF_W-1:0]   h_lo;
  logic [HALF_W-1:0]   shift_word;
  logic [IW-1:0]       rem;
  logic [IW-1:0]       rem_hi;
  logic [DCW-1:0]      div_cnt;
  logic [KW-1:0]       probe;
  logic [MODE_W-1:0]   op_mode;
  logic                found;
  logic [COUNT_W-1:0]  set_count;
  logic [IW-1:0]       m_eff;
  logic [KW-1:0]       k_eff;
  logic [RAW-1:0]      row_cnt;
  logic                clr_reply;

  logic                req_fire;
  logic                cfg_fire;
  logic                rsp_load;
  logic                div_last;
  logic                clr_last;
  logic                probe_last;
  logic                mem_we;
  logic [RAW-1:0]      mem_waddr;
  logic [ROW_BITS-1:0] mem_wdata;
  logic [RAW-1:0]      row_addr;
  logic [BSW-1:0]      bit_sel;
  logic [ROW_BITS-1:0] rd_data;
  logic                bit_set;
  logic [HASH_W-1:0]   sx;
  logic [HASH_W-1:0]   hash_upd;
  logic [HASH_W-1:0]   hash_fin;
  logic [IW-1:0]       rem_step;

  // bit store, 8 cells per row
  bf_ram #(
    .WIDTH (ROW_BITS),
    .DEPTH (ROWS)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (row_addr),
    .rdata (rd_data)
  );

  // handshake and datapath helpers
  assign cfg_ready  = 1'b1;
  assign req_fire   = req_valid && req_ready;
  assign cfg_fire   = cfg_valid && (cfg_index == REG_FILTER_BITS ||
                                    cfg_index == REG_HASH_COUNT);
  assign div_last   = (div_cnt == DCW'(DIV_CYC - 1));
  assign clr_last   = (row_cnt == RAW'(ROWS - 1));
  assign probe_last = (probe == k_eff - KW'(1));
  assign row_addr   = RAW'(rem >> BSW);
  assign bit_sel    = rem[BSW-1:0];
  assign bit_set    = rd_data[bit_sel];
  assign rem_step   = div_step(rem, shift_word[HALF_W-1 -: DIV_STEPS], m_eff);

  // djb2: h*33 + sign-extended byte
  assign sx       = {{(HASH_W - BYTE_W){req.key_byte[BYTE_W-1]}}, req.key_byte};
  assign hash_upd = (hash_acc << 5) + hash_acc + sx;
  assign hash_fin = req.has_byte ? hash_upd : hash_acc;

  // next state and control outputs
  always_comb begin
    state_next = state;
    req_ready  = 1'b0;
    rsp_load   = 1'b0;
    mem_we     = 1'b0;
    mem_waddr  = row_addr;
    mem_wdata  = rd_data | (ROW_BITS'(1) << bit_sel);
    case (state)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = row_cnt;
        mem_wdata = '0;
        if (clr_last) state_next = clr_reply ? ST_FINISH : ST_IDLE;
      end
      ST_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          if (req.mode == MODE_CLEAR) begin
            state_next = ST_CLEAR;
          end else if ((req.mode == MODE_ADD || req.mode == MODE_QUERY) && req.last_byte) begin
            state_next = ST_DIV_HI;
          end
        end
      end
      ST_DIV_HI: begin
        if (div_last) state_next = ST_DIV_LO;
      end
      ST_DIV_LO: begin
        if (div_last) state_next = ST_READ;
      end
      ST_READ: begin
        state_next = ST_CHECK;
      end
      ST_CHECK: begin
        mem_we     = (op_mode == MODE_ADD) && !bit_set;
        state_next = probe_last ? ST_FINISH : ST_DIV_LO;
      end
      ST_FINISH: begin
        rsp_load = !rsp_valid || rsp_ready;
        if (rsp_load) state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
    // a register write reinitializes the filter
    if (cfg_fire) state_next = ST_CLEAR;
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // datapath and bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      hash_acc  <= HASH_SEED;
      set_count <= '0;
      m_eff     <= eff_bits(FILTER_BITS_RESET);
      k_eff     <= eff_hashes(HASH_COUNT_RESET);
      row_cnt   <= '0;
      clr_reply <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      // output register
      if (rsp_load) begin
        rsp_valid         <= 1'b1;
        rsp.done_mode     <= op_mode;
        rsp.found         <= (op_mode == MODE_QUERY) ? found : 1'b0;
        rsp.set_bit_count <= set_count;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end

      // register write: new limits, wipe store and count, restart hash
      if (cfg_fire) begin
        if (cfg_index == REG_FILTER_BITS) begin
          m_eff <= eff_bits(cfg_data[FBITS_W-1:0]);
        end else begin
          k_eff <= eff_hashes(cfg_data[HCOUNT_W-1:0]);
        end
        set_count <= '0;
        hash_acc  <= HASH_SEED;
        row_cnt   <= '0;
        clr_reply <= 1'b0;
      end else begin
        case (state)
          ST_CLEAR: begin
            row_cnt <= clr_last ? '0 : row_cnt + RAW'(1);
          end
          ST_IDLE: begin
            if (req_fire) begin
              if (req.mode == MODE_CLEAR) begin
                op_mode   <= MODE_CLEAR;
                clr_reply <= 1'b1;
                row_cnt   <= '0;
                set_count <= '0;
                hash_acc  <= HASH_SEED;
              end else if (req.mode == MODE_ADD || req.mode == MODE_QUERY) begin
                if (req.last_byte) begin
                  h_lo       <= hash_fin[HALF_W-1:0];
                  shift_word <= hash_fin[HASH_W-1:HALF_W];
                  rem        <= '0;
                  div_cnt    <= '0;
                  probe      <= '0;
                  found      <= 1'b1;
                  op_mode    <= req.mode;
                  hash_acc   <= HASH_SEED;
                end else begin
                  hash_acc <= hash_fin;
                end
              end
            end
          end
          ST_DIV_HI: begin
            div_cnt <= div_cnt + DCW'(1);
            if (div_last) begin
              // upper half reduced once, reused as start of every probe
              rem_hi     <= rem_step;
              rem        <= rem_step;
              shift_word <= h_lo ^ crc_entry(8'(probe));
            end else begin
              rem        <= rem_step;
              shift_word <= shift_word << DIV_STEPS;
            end
          end
          ST_DIV_LO: begin
            div_cnt    <= div_cnt + DCW'(1);
            rem        <= rem_step;
            shift_word <= shift_word << DIV_STEPS;
          end
          ST_CHECK: begin
            if (op_mode == MODE_ADD && !bit_set && set_count != '1) begin
              set_count <= set_count + COUNT_W'(1);
            end
            if (op_mode == MODE_QUERY && !bit_set) found <= 1'b0;
            probe      <= probe + KW'(1);
            rem        <= rem_hi;
            div_cnt    <= '0;
            shift_word <= h_lo ^ crc_entry(8'(probe + KW'(1)));
          end
          ST_FINISH: begin
            if (rsp_load) clr_reply <= 1'b0;
          end
          default: begin
          end
        endcase
      end
    end
  end

`ifndef ASSERT_OFF
  // remainder stays reduced while the modulo unit and probe use it
  a_rem_reduced: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV_HI || state == ST_DIV_LO || state == ST_READ || state == ST_CHECK)
      |-> (rem < m_eff))
    else $error("probe remainder not below filter size");

  // probe index stays within hash_count
  a_probe_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CHECK) |-> (probe < k_eff))
    else $error("probe index beyond hash count");

  // hash restarts after a final add or query beat
  a_hash_restart: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready && req.last_byte &&
     (req.mode == MODE_ADD || req.mode == MODE_QUERY)) |=> (hash_acc == HASH_SEED))
    else $error("hash not restarted after final key beat");

  // a clear reply always reports an empty store
  a_clear_count: assert property (@(posedge clk) disable iff (rst)
    (rsp_load && op_mode == MODE_CLEAR) |-> (set_count == '0))
    else $error("clear reply with nonzero count");
`endif

endmodule
